// ----- sv/cro_pkg.sv -----
// shared widths and types for the circle / rectangle overlap unit
// no dependencies
package cro_pkg;
  localparam int unsigned CoordW = 16;
  localparam int unsigned RadW   = 15;
  localparam int unsigned DiffW  = CoordW + 1;
  localparam int unsigned MagW   = CoordW;
  localparam int unsigned SqW    = 2 * MagW;
  localparam int unsigned SumW   = SqW + 1;
  localparam int unsigned NumPts = 8;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic [RadW-1:0]          rad_t;
  typedef logic [MagW-1:0]          mag_t;
  typedef logic [SqW-1:0]           sq_t;
  typedef logic [SumW-1:0]          sum_t;

  // absolute difference of two coordinates
  function automatic mag_t abs_diff(input coord_t a, input coord_t b);
    logic signed [DiffW-1:0] d;
    logic [DiffW-1:0] m;
    d = DiffW'(a) - DiffW'(b);
    m = d[DiffW-1] ? DiffW'(-d) : DiffW'(d);
    return m[MagW-1:0];
  endfunction

  function automatic coord_t clamp(input coord_t v, input coord_t a, input coord_t b);
    coord_t lo;
    coord_t hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction
endpackage

// ----- sv/circle_rectangle_overlap_unit.sv -----
// circle versus axis-aligned rectangle overlap, four-stage pipeline
// depends on cro_pkg
//
// One query is taken per clock while stall_o is low. Its answer passes through the
// stage 1, 2 and 3 registers into the answer register and is then on the outputs;
// the result transfers when the output is not stalled. Stage 1 forms the eight probe
// points (four corners and four nearest points on the edges) as absolute
// offsets from the centre and the inside test; stage 2 squares every offset
// and the radius (sixteen 16x16 multipliers and one 15x15); stage 3 adds the
// square pairs and compares them against r^2; stage 4 combines the edge, centre and
// corner tests into the answer register. A stall holds only full stages that cannot
// pass on; stall_o is raised only when the answer register holds an untaken result
// and every stage is full, so bubbles are squeezed out under back-pressure.
module circle_rectangle_overlap_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 stall_o,
  input  cro_pkg::coord_t      center_x_i,
  input  cro_pkg::coord_t      center_y_i,
  input  cro_pkg::rad_t        radius_i,
  input  cro_pkg::coord_t      rect_left_i,
  input  cro_pkg::coord_t      rect_top_i,
  input  cro_pkg::coord_t      rect_right_i,
  input  cro_pkg::coord_t      rect_bottom_i,
  output logic                 valid_o,
  input  logic                 stall_i,
  output logic                 overlap_o
);
  import cro_pkg::*;

  // per-stage enables: a stage advances when its successor can take it
  logic v1_q, v2_q, v3_q, v4_q;
  logic en1, en2, en3, en4;
  assign en4 = !v4_q || !stall_i;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign stall_o = !en1;

  // probe points: 0..3 corners l-t, l-b, r-b, r-t; 4..7 nearest edge points
  mag_t   dx_d [NumPts];
  mag_t   dy_d [NumPts];
  logic   degen_d [4];
  logic   inside_d;
  coord_t ny_l, ny_r, nx_b, nx_t;

  always_comb begin
    ny_l = clamp(center_y_i, rect_top_i, rect_bottom_i);
    ny_r = clamp(center_y_i, rect_bottom_i, rect_top_i);
    nx_b = clamp(center_x_i, rect_left_i, rect_right_i);
    nx_t = clamp(center_x_i, rect_right_i, rect_left_i);
    dx_d[0] = abs_diff(rect_left_i,  center_x_i); dy_d[0] = abs_diff(rect_top_i,    center_y_i);
    dx_d[1] = abs_diff(rect_left_i,  center_x_i); dy_d[1] = abs_diff(rect_bottom_i, center_y_i);
    dx_d[2] = abs_diff(rect_right_i, center_x_i); dy_d[2] = abs_diff(rect_bottom_i, center_y_i);
    dx_d[3] = abs_diff(rect_right_i, center_x_i); dy_d[3] = abs_diff(rect_top_i,    center_y_i);
    dx_d[4] = abs_diff(rect_left_i,  center_x_i); dy_d[4] = abs_diff(ny_l, center_y_i);
    dx_d[5] = abs_diff(nx_b, center_x_i);         dy_d[5] = abs_diff(rect_bottom_i, center_y_i);
    dx_d[6] = abs_diff(rect_right_i, center_x_i); dy_d[6] = abs_diff(ny_r, center_y_i);
    dx_d[7] = abs_diff(nx_t, center_x_i);         dy_d[7] = abs_diff(rect_top_i,    center_y_i);
    // zero-length edges: the two endpoints coincide
    degen_d[0] = (rect_top_i == rect_bottom_i);
    degen_d[1] = (rect_left_i == rect_right_i);
    degen_d[2] = (rect_top_i == rect_bottom_i);
    degen_d[3] = (rect_left_i == rect_right_i);
    inside_d = (center_x_i >= rect_left_i) && (center_x_i <= rect_right_i) &&
               (center_y_i >= rect_top_i) && (center_y_i <= rect_bottom_i);
  end

  mag_t dx_q [NumPts];
  mag_t dy_q [NumPts];
  logic degen1_q [4];
  logic inside1_q;
  rad_t rad1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en1) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      dx_q      <= dx_d;
      dy_q      <= dy_d;
      degen1_q  <= degen_d;
      inside1_q <= inside_d;
      rad1_q    <= radius_i;
    end
  end

  // stage 2: squares
  sq_t  sx_q [NumPts];
  sq_t  sy_q [NumPts];
  sq_t  r2_q;
  logic degen2_q [4];
  logic inside2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en2) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      for (int i = 0; i < NumPts; i++) begin
        sx_q[i] <= SqW'(dx_q[i]) * SqW'(dx_q[i]);
        sy_q[i] <= SqW'(dy_q[i]) * SqW'(dy_q[i]);
      end
      r2_q      <= SqW'(rad1_q) * SqW'(rad1_q);
      degen2_q  <= degen1_q;
      inside2_q <= inside1_q;
    end
  end

  // stage 3: distance versus radius, le = on or within, ge = on or outside
  logic le_d [NumPts];
  logic ge_d [NumPts];
  sum_t dist_sum;

  always_comb begin
    for (int i = 0; i < NumPts; i++) begin
      dist_sum = SumW'(sx_q[i]) + SumW'(sy_q[i]);
      le_d[i] = dist_sum <= SumW'(r2_q);
      ge_d[i] = dist_sum >= SumW'(r2_q);
    end
  end

  logic le_q [NumPts];
  logic ge_q [NumPts];
  logic degen3_q [4];
  logic inside3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en3) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3) begin
      le_q      <= le_d;
      ge_q      <= ge_d;
      degen3_q  <= degen2_q;
      inside3_q <= inside2_q;
    end
  end

  // stage 4: combine; edge k runs from corner k to corner k+1
  logic edge_hit [4];
  logic hit_d;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      edge_hit[k] = !degen3_q[k] && le_q[k+4] && (ge_q[k] || ge_q[(k+1)%4]);
    end
    hit_d = inside3_q || edge_hit[0] || edge_hit[1] || edge_hit[2] || edge_hit[3] ||
            (le_q[0] && le_q[1] && le_q[2] && le_q[3]);
  end

  logic hit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (en4) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en4) begin
      hit_q <= hit_d;
    end
  end

  assign valid_o   = v4_q;
  assign overlap_o = hit_q;

  // a stalled answer holds its value while it waits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(valid_o && stall_i) |-> valid_o && $stable(overlap_o))
    else $error("answer changed under stall");

  // back-pressure only when the pipe is full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> v1_q && v2_q && v3_q && v4_q)
    else $error("stall raised with a bubble in the pipe");

  // an empty output stage never stalls the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v4_q |-> !stall_o)
    else $error("input stalled with an empty output stage");
endmodule

// ----- dv/circle_rectangle_overlap_unit_tb.sv -----
// self-checking testbench for the circle / rectangle overlap unit
// depends on cro_pkg and circle_rectangle_overlap_unit
module circle_rectangle_overlap_unit_tb;
  import cro_pkg::*;

  localparam int unsigned NumRandom = 1350;
  localparam int unsigned IdleLimit = 20000;
  localparam int unsigned Drain     = 12;

  // one query as driven into the block
  typedef struct packed {
    coord_t cx;
    coord_t cy;
    rad_t   r;
    coord_t l;
    coord_t t;
    coord_t rt;
    coord_t b;
  } query_t;

  // predicts each answer and checks it against the block
  class overlap_scoreboard;
    bit   answers_q[$];
    int   mismatches;
    int   checked;
    int   hits;

    // sign of |p - c|^2 - r2, all in wide signed arithmetic
    static function int dist_sign(longint px, longint py, longint cx, longint cy,
                                  longint r2);
      longint d;
      d = (px - cx) * (px - cx) + (py - cy) * (py - cy) - r2;
      return (d > 0) ? 1 : ((d == 0) ? 0 : -1);
    endfunction

    static function longint clip(longint v, longint a, longint b);
      longint lo;
      longint hi;
      lo = (a < b) ? a : b;
      hi = (a < b) ? b : a;
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
    endfunction

    // axis-aligned edge meets the circle boundary
    static function bit edge_meets(longint x0, longint y0, longint x1, longint y1,
                                   longint cx, longint cy, longint r2);
      longint nx;
      longint ny;
      if (x0 == x1 && y0 == y1) return 0;
      if (x0 == x1) begin
        nx = x0;
        ny = clip(cy, y0, y1);
      end else begin
        nx = clip(cx, x0, x1);
        ny = y0;
      end
      if (dist_sign(nx, ny, cx, cy, r2) > 0) return 0;
      return dist_sign(x0, y0, cx, cy, r2) >= 0 || dist_sign(x1, y1, cx, cy, r2) >= 0;
    endfunction

    static function bit predict_overlap(query_t q);
      longint cx;
      longint cy;
      longint l;
      longint t;
      longint rt;
      longint b;
      longint r2;
      bit hit;
      cx = longint'(q.cx);
      cy = longint'(q.cy);
      l  = longint'(q.l);
      t  = longint'(q.t);
      rt = longint'(q.rt);
      b  = longint'(q.b);
      r2 = longint'({1'b0, q.r}) * longint'({1'b0, q.r});
      hit = cx >= l && cx <= rt && cy >= t && cy <= b;
      if (!hit)
        hit = edge_meets(l, t, l, b, cx, cy, r2) || edge_meets(l, b, rt, b, cx, cy, r2) ||
              edge_meets(rt, b, rt, t, cx, cy, r2) || edge_meets(rt, t, l, t, cx, cy, r2);
      if (!hit)
        hit = dist_sign(l, t, cx, cy, r2) <= 0 && dist_sign(l, b, cx, cy, r2) <= 0 &&
              dist_sign(rt, b, cx, cy, r2) <= 0 && dist_sign(rt, t, cx, cy, r2) <= 0;
      return hit;
    endfunction

    function void note_query(query_t q);
      answers_q.push_back(predict_overlap(q));
    endfunction

    function void check_answer(bit got);
      bit want;
      checked++;
      if (got) hits++;
      if (answers_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected answer %0d with none pending", got);
        return;
      end
      want = answers_q.pop_front();
      if (want != got) begin
        mismatches++;
        if (mismatches <= 10)
          $display("overlap mismatch at answer %0d: expected %0d, got %0d",
                   checked, want, got);
      end
    endfunction
  endclass

  logic   clk_i;
  logic   rst_ni;
  logic   valid_i;
  logic   stall_o;
  query_t q_drv;
  logic   valid_o;
  logic   stall_i;
  logic   overlap_o;

  overlap_scoreboard sb;
  int  sent = 0;
  int  idle_cycles = 0;
  bit  sink_on;

  circle_rectangle_overlap_unit uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (valid_i),
    .stall_o      (stall_o),
    .center_x_i   (q_drv.cx),
    .center_y_i   (q_drv.cy),
    .radius_i     (q_drv.r),
    .rect_left_i  (q_drv.l),
    .rect_top_i   (q_drv.t),
    .rect_right_i (q_drv.rt),
    .rect_bottom_i(q_drv.b),
    .valid_o      (valid_o),
    .stall_i      (stall_i),
    .overlap_o    (overlap_o)
  );

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // gap length: mostly short, now and then long
  function automatic int pick_gap();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 55) return 0;
    if (sel < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // sample both transfers at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (valid_i && !stall_o) begin
        sb.note_query(q_drv);
        sent++;
      end
      if (valid_o && !stall_i) sb.check_answer(overlap_o);
      if ((valid_i && !stall_o) || (valid_o && !stall_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("watchdog: no transfer for %0d cycles", IdleLimit);
        $display("circle_rectangle_overlap_unit_tb failed");
        $finish;
      end
    end
  end

  // receiver back-pressure, changed at the falling edge
  initial begin
    int g;
    stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (sink_on) begin
        g = pick_gap();
        if (g > 0) begin
          stall_i <= 1'b1;
          repeat (g) @(negedge clk_i);
        end
        stall_i <= 1'b0;
        repeat ($urandom_range(0, 6)) @(negedge clk_i);
      end
    end
  end

  // present one query and hold it until transferred
  task automatic send_query(query_t q, bit with_gap);
    int g;
    g = with_gap ? pick_gap() : 0;
    if (g > 0) begin
      valid_i <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
    valid_i <= 1'b1;
    q_drv   <= q;
    @(posedge clk_i);
    while (stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_fields(int cx, int cy, int r, int l, int t, int rt, int b);
    query_t q;
    q.cx = coord_t'(cx);
    q.cy = coord_t'(cy);
    q.r  = rad_t'(r);
    q.l  = coord_t'(l);
    q.t  = coord_t'(t);
    q.rt = coord_t'(rt);
    q.b  = coord_t'(b);
    send_query(q, 1'b1);
  endtask

  function automatic int near_coord(int base, int span);
    int v;
    v = base + $urandom_range(0, 2 * span) - span;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v;
  endfunction

  // random query: mostly geometry near the boundary, some raw noise
  function automatic query_t random_query();
    query_t q;
    int sel;
    int span;
    int l;
    int t;
    int w;
    int h;
    sel = $urandom_range(0, 9);
    q = query_t'({$urandom, $urandom, $urandom});
    if (sel < 2) return q;
    span = (sel < 6) ? 64 : 4000;
    l = near_coord(0, 20000);
    t = near_coord(0, 20000);
    w = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, span);
    h = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, span);
    if ($urandom_range(0, 15) == 0) w = -w;
    q.l  = coord_t'(l);
    q.t  = coord_t'(t);
    q.rt = coord_t'(near_coord(l, 0) + w);
    q.b  = coord_t'(near_coord(t, 0) + h);
    q.cx = coord_t'(near_coord(l + w / 2, span + 2 * span / 3));
    q.cy = coord_t'(near_coord(t + h / 2, span + 2 * span / 3));
    q.r  = rad_t'($urandom_range(0, 7) == 0 ? $urandom_range(0, 32767)
                                            : $urandom_range(0, span));
    return q;
  endfunction

  initial begin
    sb = new();
    sink_on = 1'b0;
    rst_ni = 1'b0;
    valid_i = 1'b0;
    q_drv = '0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    sink_on = 1'b1;

    // directed: centre inside, edge crossing, corners enclosed, misses
    send_fields(0, 0, 0, -10, -10, 10, 10);
    send_fields(20, 0, 10, -10, -10, 10, 10);
    send_fields(25, 0, 10, -10, -10, 10, 10);
    send_fields(21, 0, 10, -10, -10, 10, 10);
    send_fields(0, 0, 100, -10, -10, 10, 10);
    send_fields(30, 30, 28, -10, -10, 10, 10);
    send_fields(13, 14, 5, 10, 10, 10, 10);
    send_fields(13, 14, 4, 10, 10, 10, 10);
    send_fields(10, 10, 0, 10, 10, 10, 10);
    send_fields(0, 0, 5, 10, 10, -10, -10);
    send_fields(0, 0, 15, 10, 10, -10, -10);
    send_fields(-32768, -32768, 32767, 32767, 32767, 32767, 32767);
    send_fields(32767, 32767, 32767, -32768, -32768, -32768, -32768);
    send_fields(32767, -32768, 0, -32768, -32768, 32767, 32767);
    send_fields(0, 0, 32767, -32768, -32768, 32767, 32767);
    send_fields(0, 0, 32767, -100, -100, 100, 100);
    send_fields(-32768, 0, 1, -32767, -5, -32767, 5);
    send_fields(5, 5, 3, 0, 0, 10, 0);
    send_fields(5, 3, 3, 0, 0, 10, 0);
    send_fields(5, 2, 3, 0, 0, 10, 0);

    // hold-off until everything directed has come back
    valid_i <= 1'b0;
    while (sb.answers_q.size() != 0) @(negedge clk_i);

    for (int i = 0; i < NumRandom; i++) begin
      // one stretch with no source gaps
      send_query(random_query(), !(i >= 400 && i < 600));
    end
    valid_i <= 1'b0;

    while (sb.answers_q.size() != 0) @(negedge clk_i);
    repeat (Drain) @(negedge clk_i);

    $display("sent %0d queries, checked %0d answers (%0d overlaps), %0d mismatches",
             sent, sb.checked, sb.hits, sb.mismatches);
    if (sb.mismatches == 0 && sb.answers_q.size() == 0)
      $display("circle_rectangle_overlap_unit_tb passed");
    else
      $display("circle_rectangle_overlap_unit_tb failed");
    $finish;
  end
endmodule

// ----- sim.f -----
sv/cro_pkg.sv
sv/circle_rectangle_overlap_unit.sv
dv/circle_rectangle_overlap_unit_tb.sv
